### rtl/bpc_pkg.sv
// Shared types, constants and status codes of the BPC time code decoder.
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int LEN_W          = 16;
    localparam int CMP_W          = CFG_W + 1;

    localparam int FRAME_DIGITS   = 10;
    localparam int IDX_W          = 4;

    localparam int D_P1 = 0;
    localparam int D_H1 = 2;
    localparam int D_H2 = 3;
    localparam int D_M1 = 4;
    localparam int D_M2 = 5;
    localparam int D_M3 = 6;
    localparam int D_P3 = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH3    = 3'd5;

    localparam logic [CFG_W-1:0] RST_START_LOW = 16'd1000;
    localparam logic [CFG_W-1:0] RST_TOLERANCE = 16'd40;
    localparam logic [CFG_W-1:0] RST_WIDTH0    = 16'd100;
    localparam logic [CFG_W-1:0] RST_WIDTH1    = 16'd200;
    localparam logic [CFG_W-1:0] RST_WIDTH2    = 16'd300;
    localparam logic [CFG_W-1:0] RST_WIDTH3    = 16'd400;

    localparam logic [2:0] ST_IGNORED   = 3'd0;
    localparam logic [2:0] ST_START     = 3'd1;
    localparam logic [2:0] ST_DIGIT     = 3'd2;
    localparam logic [2:0] ST_PULSE_ERR = 3'd3;
    localparam logic [2:0] ST_NO_START  = 3'd4;
    localparam logic [2:0] ST_FRAME_OK  = 3'd5;
    localparam logic [2:0] ST_REJECTED  = 3'd6;

    localparam logic [5:0] SEC_BASE = 6'd10;
    localparam logic [5:0] SEC_P1_1 = 6'd20;
    localparam logic [5:0] SEC_P1_2 = 6'd40;
    localparam logic [4:0] HOUR_PM  = 5'd12;

    typedef enum logic [1:0] {
        EV_IGNORE    = 2'd0,
        EV_START     = 2'd1,
        EV_DIGIT     = 2'd2,
        EV_PULSE_ERR = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] digit;
    } t_evt;

endpackage

### rtl/bpc_front.sv
// Front end: configuration registers and classification of measured periods.
`timescale 1ns / 1ps

module bpc_front #(
    parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpc_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_low_phase,
    input  logic [bpc_pkg::LEN_W-1:0]      i_low_length,
    input  logic [bpc_pkg::LEN_W-1:0]      i_high_length,
    output bpc_pkg::t_evt                  o_evt
);
    import bpc_pkg::*;

    localparam logic [CFG_W-1:0] MASK = (COUNT_BITS >= CFG_W) ? {CFG_W{1'b1}} :
                                        CFG_W'((64'd1 << COUNT_BITS) - 64'd1);

    logic [CFG_W-1:0] r_start_low;
    logic [CFG_W-1:0] r_tol;
    logic [CFG_W-1:0] r_width [4];
    logic [CFG_W-1:0] cfg_val;

    logic [CMP_W-1:0] lo_ext;
    logic [CMP_W-1:0] start_sum;
    logic [CFG_W-1:0] hi_len;
    logic [CFG_W-1:0] delta [4];
    logic [3:0]       hit;

    assign cfg_val = i_cfg_data & MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_low <= RST_START_LOW;
            r_tol       <= RST_TOLERANCE;
            r_width[0]  <= RST_WIDTH0;
            r_width[1]  <= RST_WIDTH1;
            r_width[2]  <= RST_WIDTH2;
            r_width[3]  <= RST_WIDTH3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_LOW: r_start_low <= cfg_val;
                CFG_TOLERANCE: r_tol       <= cfg_val;
                CFG_WIDTH0:    r_width[0]  <= cfg_val;
                CFG_WIDTH1:    r_width[1]  <= cfg_val;
                CFG_WIDTH2:    r_width[2]  <= cfg_val;
                CFG_WIDTH3:    r_width[3]  <= cfg_val;
                default: begin
                end
            endcase
        end
    end

    assign lo_ext    = CMP_W'(i_low_length & MASK);
    assign start_sum = lo_ext + CMP_W'(r_tol);
    assign hi_len    = i_high_length & MASK;

    always_comb begin
        for (int n = 0; n < 4; n++) begin
            delta[n] = (hi_len >= r_width[n]) ? hi_len - r_width[n] : r_width[n] - hi_len;
            hit[n]   = delta[n] < r_tol;
        end
    end

    always_comb begin
        o_evt.digit = 2'd0;
        o_evt.kind  = EV_IGNORE;
        if (i_low_phase) begin
            o_evt.kind = (start_sum > CMP_W'(r_start_low)) ? EV_START : EV_IGNORE;
        end else begin
            o_evt.kind = EV_DIGIT;
            priority if (hit[0]) begin
                o_evt.digit = 2'd0;
            end else if (hit[1]) begin
                o_evt.digit = 2'd1;
            end else if (hit[2]) begin
                o_evt.digit = 2'd2;
            end else if (hit[3]) begin
                o_evt.digit = 2'd3;
            end else begin
                o_evt.kind = EV_PULSE_ERR;
            end
        end
    end

endmodule

### rtl/bpc_queue.sv
// Two-entry queue of classified events between front and back end.
`timescale 1ns / 1ps

module bpc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bpc_pkg::t_evt i_wr_data,
    output logic          o_full,
    output logic          o_valid,
    output bpc_pkg::t_evt o_rd_data,
    input  logic          i_pop
);
    import bpc_pkg::*;

    t_evt       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full    = (r_count == 2'd2);
    assign o_valid   = (r_count != 2'd0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### rtl/bpc_back.sv
// Back end: frame state, digit store, time decode and output register.
`timescale 1ns / 1ps

module bpc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_evt_valid,
    input  bpc_pkg::t_evt i_evt,
    output logic          o_evt_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [2:0]    o_status,
    output logic [4:0]    o_hour,
    output logic [5:0]    o_minute,
    output logic [5:0]    o_second,
    output logic          o_time_changed
);
    import bpc_pkg::*;

    logic             r_receiving;
    logic             n_receiving;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [IDX_W-1:0] idx_eff;
    logic [1:0]       r_store [FRAME_DIGITS];
    logic [4:0]       r_hour;
    logic [4:0]       n_hour;
    logic [5:0]       r_minute;
    logic [5:0]       n_minute;
    logic [5:0]       r_second;
    logic [5:0]       n_second;

    logic             r_out_valid;
    logic [2:0]       r_status;
    logic [4:0]       r_out_hour;
    logic [5:0]       r_out_minute;
    logic [5:0]       r_out_second;
    logic             r_changed;

    logic [2:0]       status;
    logic             changed;
    logic             wr_en;
    logic [1:0]       xsum;
    logic             par;
    logic [4:0]       hour_dec;
    logic [5:0]       minute_dec;
    logic [5:0]       second_dec;

    assign o_evt_pop = i_evt_valid && (!r_out_valid || !i_out_stall);
    assign idx_eff   = (r_idx >= IDX_W'(FRAME_DIGITS)) ? '0 : r_idx;

    always_comb begin
        xsum = 2'd0;
        for (int i = D_P1; i < D_P3; i++) begin
            xsum = xsum ^ r_store[i];
        end
        par = xsum[0] ^ xsum[1];
    end

    assign hour_dec   = {1'b0, r_store[D_H1], 2'b00} + {3'b000, r_store[D_H2]}
                        + (i_evt.digit[1] ? HOUR_PM : 5'd0);
    assign minute_dec = {r_store[D_M1], 4'b0000} + {2'b00, r_store[D_M2], 2'b00}
                        + {4'b0000, r_store[D_M3]};
    assign second_dec = SEC_BASE + ((r_store[D_P1] == 2'd1) ? SEC_P1_1 :
                                    (r_store[D_P1] == 2'd2) ? SEC_P1_2 : 6'd0);

    always_comb begin
        n_receiving = r_receiving;
        n_idx       = r_idx;
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_second    = r_second;
        status      = ST_IGNORED;
        changed     = 1'b0;
        wr_en       = 1'b0;
        unique case (i_evt.kind)
            EV_IGNORE: begin
                status = ST_IGNORED;
            end
            EV_START: begin
                n_receiving = 1'b1;
                n_idx       = '0;
                status      = ST_START;
            end
            EV_PULSE_ERR: begin
                n_receiving = 1'b0;
                n_idx       = '0;
                status      = ST_PULSE_ERR;
            end
            EV_DIGIT: begin
                if (!r_receiving) begin
                    n_idx  = '0;
                    status = ST_NO_START;
                end else begin
                    wr_en = 1'b1;
                    if (idx_eff == IDX_W'(D_P3)) begin
                        n_receiving = 1'b0;
                        n_idx       = '0;
                        if (r_store[D_P1] == 2'd3 || i_evt.digit[0] != par) begin
                            status = ST_REJECTED;
                        end else begin
                            status   = ST_FRAME_OK;
                            changed  = (hour_dec != r_hour) || (minute_dec != r_minute);
                            n_hour   = hour_dec;
                            n_minute = minute_dec;
                            n_second = second_dec;
                        end
                    end else begin
                        n_idx  = idx_eff + IDX_W'(1);
                        status = ST_DIGIT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_idx       <= '0;
            r_hour      <= '0;
            r_minute    <= '0;
            r_second    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_evt_pop) begin
                r_receiving <= n_receiving;
                r_idx       <= n_idx;
                r_hour      <= n_hour;
                r_minute    <= n_minute;
                r_second    <= n_second;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_evt_pop) begin
            r_status     <= status;
            r_out_hour   <= n_hour;
            r_out_minute <= n_minute;
            r_out_second <= n_second;
            r_changed    <= changed;
        end
        if (o_evt_pop && wr_en) begin
            r_store[idx_eff] <= i_evt.digit;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_hour         = r_out_hour;
    assign o_minute       = r_out_minute;
    assign o_second       = r_out_second;
    assign o_time_changed = r_changed;

endmodule

### rtl/bpc_time_code_decoder_top.sv
// Top level of the BPC time code decoder.
//
// Input channel (i_in_valid / o_in_stall) carries one measured level period:
// i_low_phase selects a low period (i_low_length) or a high pulse
// (i_high_length). Each transfer yields exactly one result on the output
// channel (o_out_valid / i_out_stall): status, current hour, minute, second
// and a time-changed flag for a frame that moved hour or minute.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 start count, 1 tolerance, 2..5 digit widths); write only while idle.
// The front classification enters the two-entry queue at the input transfer,
// and the back end pops it into the output register when that register is
// empty or not stalled. Throughput: one item per cycle while i_out_stall is
// low, set by the back-end state update.
// Reset (synchronous, active low) restores the default register values,
// searches for a frame start and clears hour, minute and second.
// When the receiver stalls, the result holds; the queue absorbs up to two
// more items before o_in_stall rises.
`timescale 1ns / 1ps

module bpc_time_code_decoder_top #(
    parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpc_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_low_phase,
    input  logic [bpc_pkg::LEN_W-1:0]      i_low_length,
    input  logic [bpc_pkg::LEN_W-1:0]      i_high_length,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_status,
    output logic [4:0]                     o_hour,
    output logic [5:0]                     o_minute,
    output logic [5:0]                     o_second,
    output logic                           o_time_changed
);
    import bpc_pkg::*;

    t_evt front_evt;
    t_evt queue_evt;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic push;

    assign o_in_stall = queue_full;
    assign push       = i_in_valid && !queue_full;

    bpc_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_low_phase   (i_low_phase),
        .i_low_length  (i_low_length),
        .i_high_length (i_high_length),
        .o_evt         (front_evt)
    );

    bpc_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (front_evt),
        .o_full    (queue_full),
        .o_valid   (queue_valid),
        .o_rd_data (queue_evt),
        .i_pop     (queue_pop)
    );

    bpc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_evt_valid    (queue_valid),
        .i_evt          (queue_evt),
        .o_evt_pop      (queue_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second       (o_second),
        .o_time_changed (o_time_changed)
    );

endmodule

### rtl/bpc_checker.sv
// Port-level checker for the BPC time code decoder, bound to the top level.
`timescale 1ns / 1ps

module bpc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_status,
    input logic [4:0] o_hour,
    input logic [5:0] o_minute,
    input logic [5:0] o_second,
    input logic       o_time_changed
);
    import bpc_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_changed_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_time_changed |-> o_status == ST_FRAME_OK)
        else $error("time change flagged without accepted frame");

    a_second_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_second == 6'd0 || o_second == 6'd10 ||
                         o_second == 6'd30 || o_second == 6'd50))
        else $error("second out of decoded set");

    a_time_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall ##1 o_out_valid && o_status != ST_FRAME_OK
        |-> $stable(o_hour) || !$past(o_out_valid, 1) || $past(i_out_stall, 1) ||
            o_hour == $past(o_hour, 1))
        else $error("hour moved without accepted frame");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
                                       $stable(o_minute))
        else $error("stalled result changed");

endmodule

bind bpc_time_code_decoder_top bpc_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_hour         (o_hour),
    .o_minute       (o_minute),
    .o_second       (o_second),
    .o_time_changed (o_time_changed)
);

### tb/bpc_time_code_decoder_top_tb.sv
// Self-checking testbench for the BPC time code decoder: random pulse frames against a predictor.
`timescale 1ns / 1ps

module bpc_time_code_decoder_top_tb;
    import bpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 150;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       changed;
    } t_time_report;

    class bpc_decode_scoreboard;
        logic [15:0]  start_cnt;
        logic [15:0]  tol_cnt;
        logic [15:0]  width [4];
        bit           receiving;
        int           digit_idx;
        logic [1:0]   digits [FRAME_DIGITS];
        logic [4:0]   hour;
        logic [5:0]   minute;
        logic [5:0]   second;
        t_time_report reports_q [$];
        int           errors;
        int           results_seen;

        function new();
            start_cnt    = RST_START_LOW;
            tol_cnt      = RST_TOLERANCE;
            width[0]     = RST_WIDTH0;
            width[1]     = RST_WIDTH1;
            width[2]     = RST_WIDTH2;
            width[3]     = RST_WIDTH3;
            receiving    = 1'b0;
            digit_idx    = 0;
            hour         = '0;
            minute       = '0;
            second       = '0;
            errors       = 0;
            results_seen = 0;
            foreach (digits[i]) digits[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
            case (idx)
                CFG_START_LOW: start_cnt = v;
                CFG_TOLERANCE: tol_cnt = v;
                CFG_WIDTH0:    width[0] = v;
                CFG_WIDTH1:    width[1] = v;
                CFG_WIDTH2:    width[2] = v;
                CFG_WIDTH3:    width[3] = v;
                default: ;
            endcase
        endfunction

        function int pulse_digit(logic [15:0] len);
            logic [15:0] d;
            int          n;
            for (n = 0; n < 4; n++) begin
                d = (len > width[n]) ? len - width[n] : width[n] - len;
                if (d < tol_cnt) return n;
            end
            return 4;
        endfunction

        function logic [2:0] close_frame(output logic changed);
            logic [1:0] x;
            int         h;
            int         m;
            int         i;
            changed   = 1'b0;
            receiving = 1'b0;
            digit_idx = 0;
            if (digits[D_P1] > 2'd2) return ST_REJECTED;
            x = '0;
            for (i = D_P1; i < D_P3; i++) x ^= digits[i];
            if (digits[D_P3][0] != (x[0] ^ x[1])) return ST_REJECTED;
            h = int'(digits[D_H1]) * 4 + int'(digits[D_H2])
                + (digits[D_P3][1] ? int'(HOUR_PM) : 0);
            m = int'(digits[D_M1]) * 16 + int'(digits[D_M2]) * 4 + int'(digits[D_M3]);
            changed = (h != int'(hour)) || (m != int'(minute));
            hour    = h[4:0];
            minute  = m[5:0];
            second  = SEC_BASE + ((digits[D_P1] == 2'd1) ? SEC_P1_1 :
                                  (digits[D_P1] == 2'd2) ? SEC_P1_2 : 6'd0);
            return ST_FRAME_OK;
        endfunction

        function void note_period(bit lp, logic [15:0] lo, logic [15:0] hi);
            t_time_report r;
            int           d;
            logic         changed;
            changed = 1'b0;
            if (lp) begin
                if ({1'b0, lo} + {1'b0, tol_cnt} > {1'b0, start_cnt}) begin
                    receiving = 1'b1;
                    digit_idx = 0;
                    r.status  = ST_START;
                end else begin
                    r.status = ST_IGNORED;
                end
            end else begin
                d = pulse_digit(hi);
                if (d > 3) begin
                    receiving = 1'b0;
                    digit_idx = 0;
                    r.status  = ST_PULSE_ERR;
                end else if (!receiving) begin
                    digit_idx = 0;
                    r.status  = ST_NO_START;
                end else begin
                    if (digit_idx >= FRAME_DIGITS) digit_idx = 0;
                    digits[digit_idx] = d[1:0];
                    digit_idx++;
                    if (digit_idx < FRAME_DIGITS) r.status = ST_DIGIT;
                    else r.status = close_frame(changed);
                end
            end
            r.hour    = hour;
            r.minute  = minute;
            r.second  = second;
            r.changed = changed;
            reports_q.push_back(r);
        endfunction

        function void check_report(logic [2:0] st, logic [4:0] h, logic [5:0] m,
                                   logic [5:0] s, logic tc);
            t_time_report e;
            results_seen++;
            if (reports_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, status %0d", $time, st);
                return;
            end
            e = reports_q.pop_front();
            if (st !== e.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            end
            if (h !== e.hour) begin
                errors++;
                $display("%0t: hour expected %0d actual %0d", $time, e.hour, h);
            end
            if (m !== e.minute) begin
                errors++;
                $display("%0t: minute expected %0d actual %0d", $time, e.minute, m);
            end
            if (s !== e.second) begin
                errors++;
                $display("%0t: second expected %0d actual %0d", $time, e.second, s);
            end
            if (tc !== e.changed) begin
                errors++;
                $display("%0t: time_changed expected %0d actual %0d", $time, e.changed, tc);
            end
        endfunction

        function int pending();
            return reports_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_low_phase;
    logic [LEN_W-1:0]     i_low_length;
    logic [LEN_W-1:0]     i_high_length;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [2:0]           o_status;
    logic [4:0]           o_hour;
    logic [5:0]           o_minute;
    logic [5:0]           o_second;
    logic                 o_time_changed;

    bpc_decode_scoreboard sb = new();

    int burst_left   = 0;
    int idle_cycles  = 0;
    int hold_cnt     = 0;
    bit hold_done    = 1'b0;
    int stall_mode   = 0;
    int mode_left    = 0;
    int rx_cycle     = 0;
    int items_sent   = 0;

    bpc_time_code_decoder_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_low_phase    (i_low_phase),
        .i_low_length   (i_low_length),
        .i_high_length  (i_high_length),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second       (o_second),
        .o_time_changed (o_time_changed)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        rx_cycle++;
        if (hold_cnt > 0) begin
            i_out_stall = 1'b1;
            hold_cnt--;
        end else if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
            hold_done   = 1'b1;
            hold_cnt    = HOLD_CYCLES - 1;
            i_out_stall = 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                0: i_out_stall = 1'b0;
                1: i_out_stall = ($urandom_range(0, 99) < 30);
                2: i_out_stall = ($urandom_range(0, 99) < 75);
                default: i_out_stall = (rx_cycle % 4) != 0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_report(o_status, o_hour, o_minute, o_second, o_time_changed);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("bpc_time_code_decoder_top test failed");
            $finish;
        end
    end

    function automatic logic [15:0] start_len();
        int lo_min;
        int span;
        lo_min = int'(sb.start_cnt) - int'(sb.tol_cnt) + 1;
        if (lo_min < 0) lo_min = 0;
        if (lo_min > 65535) return 16'hFFFF;
        if ($urandom_range(0, 3) == 0) return 16'($urandom_range(65535, lo_min));
        span = (65535 - lo_min < 200) ? 65535 - lo_min : 200;
        return 16'(lo_min + int'($urandom_range(0, span)));
    endfunction

    function automatic logic [15:0] near_width(logic [15:0] w);
        int t;
        int off;
        int v;
        t = int'(sb.tol_cnt);
        if (t == 0) return w;
        off = int'($urandom_range(0, t - 1));
        if ($urandom_range(0, 3) == 0) off = t - 1;
        v = $urandom_range(0, 1) ? int'(w) + off : int'(w) - off;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    task automatic send_period(bit lp, logic [15:0] lo, logic [15:0] hi);
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_low_phase   = lp;
        i_low_length  = lo;
        i_high_length = hi;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_period(lp, lo, hi);
        items_sent++;
        if (burst_left == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_frame(int p1, bit bad_parity, bit pm, bit broken);
        logic [1:0] dg [FRAME_DIGITS];
        logic [1:0] x;
        int         brk_pos;
        int         i;
        dg[0] = 2'(p1);
        x     = dg[0];
        for (i = 1; i < D_P3; i++) begin
            dg[i] = 2'($urandom_range(0, 3));
            x ^= dg[i];
        end
        dg[D_P3] = {pm, (x[0] ^ x[1]) ^ bad_parity};
        brk_pos  = broken ? int'($urandom_range(0, FRAME_DIGITS - 1)) : FRAME_DIGITS;
        send_period(1'b1, start_len(), 16'($urandom));
        for (i = 0; i < FRAME_DIGITS; i++) begin
            if (sb.start_cnt >= sb.tol_cnt && $urandom_range(0, 2) == 0)
                send_period(1'b1, 16'($urandom_range(0, sb.start_cnt - sb.tol_cnt)),
                            16'($urandom));
            if (i == brk_pos) begin
                if ($urandom_range(0, 1))
                    send_period(1'b1, start_len(), 16'($urandom));
                else
                    send_period(1'b0, 16'($urandom), 16'($urandom));
            end
            send_period(1'b0, 16'($urandom), near_width(sb.width[dg[i]]));
        end
    endtask

    task automatic run_random(int n);
        int target;
        int p1;
        target = items_sent + n;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 70) begin
                p1 = ($urandom_range(0, 99) < 5) ? 3 : int'($urandom_range(0, 2));
                send_frame(p1, $urandom_range(0, 99) < 10, $urandom_range(0, 1),
                           $urandom_range(0, 99) < 10);
            end else begin
                case ($urandom_range(0, 3))
                    0: send_period(1'b1, 16'($urandom), 16'($urandom));
                    1: send_period(1'b0, 16'($urandom), 16'($urandom));
                    2: send_period(1'b0, 16'($urandom),
                                   near_width(sb.width[$urandom_range(0, 3)]));
                    default: send_period(1'b1, start_len(), 16'($urandom));
                endcase
            end
        end
    endtask

    task automatic drain_block();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.write_reg(idx, v);
    endtask

    task automatic cfg_all(logic [15:0] s, logic [15:0] t, logic [15:0] w0,
                           logic [15:0] w1, logic [15:0] w2, logic [15:0] w3);
        drain_block();
        cfg_write(CFG_START_LOW, s);
        cfg_write(CFG_TOLERANCE, t);
        cfg_write(CFG_WIDTH0, w0);
        cfg_write(CFG_WIDTH1, w1);
        cfg_write(CFG_WIDTH2, w2);
        cfg_write(CFG_WIDTH3, w3);
    endtask

    initial begin
        int tol;
        int w0;
        int step;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_low_phase   = 1'b0;
        i_low_length  = '0;
        i_high_length = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: thresholds, searching, aborts and restart at reset values
        send_period(1'b1, 16'd0, 16'd0);
        send_period(1'b0, 16'hFFFF, 16'd100);
        send_period(1'b0, 16'd0, 16'd0);
        send_period(1'b0, 16'd0, 16'hFFFF);
        send_period(1'b1, 16'd960, 16'd0);
        send_period(1'b1, 16'd961, 16'd0);
        send_period(1'b0, 16'd0, 16'd139);
        send_period(1'b0, 16'd0, 16'd200);
        send_period(1'b1, 16'hFFFF, 16'hFFFF);
        send_period(1'b0, 16'd0, 16'd140);
        send_frame(2, 1'b0, 1'b1, 1'b0);

        run_random(280);

        tol  = $urandom_range(5, 60);
        w0   = $urandom_range(30, 400);
        step = 2 * tol + int'($urandom_range(0, 100));
        cfg_all(16'($urandom_range(500, 30000)), 16'(tol), 16'(w0), 16'(w0 + step),
                16'(w0 + 2 * step), 16'(w0 + 3 * step));
        run_random(250);

        cfg_all(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'h8000, 16'd1);
        run_random(60);

        cfg_all(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd1, 16'h8000);
        run_random(40);

        cfg_all(16'hFFFF, 16'd1, 16'd0, 16'd1, 16'hFFFE, 16'hFFFF);
        run_random(100);

        cfg_all(RST_START_LOW, RST_TOLERANCE, RST_WIDTH0, RST_WIDTH1, RST_WIDTH2, RST_WIDTH3);
        run_random(100);

        drain_block();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("bpc_time_code_decoder_top test passed");
        else
            $display("bpc_time_code_decoder_top test failed");
        $finish;
    end

endmodule
